// ===== sv/lsps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status pattern sequencer - shared package
// Types, codes, register indexes and the breathe sine ROM contents.
// ----------------------------------------------------------------------------
package lsps_pkg;

   // Widths
   localparam int DUTY_BITS       = 13;
   localparam int SINE_INDEX_BITS = 10;
   localparam int PHASE_BITS      = 16;
   localparam int LEN_BITS        = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int TABLE_SIZE      = 1 << SINE_INDEX_BITS;

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
   localparam logic [DUTY_BITS-1:0] DUTY_OFF = '0;

   // Input operation codes
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SET_MODE = 2'd1,
      OP_RX_FLASH = 2'd2,
      OP_TX_FLASH = 2'd3
   } op_type;

   // Display modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_CONNECT = 3'd1,
      MODE_THINK   = 3'd2,
      MODE_TOOL    = 3'd3,
      MODE_ERROR   = 3'd4
   } mode_type;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLINK_HALF = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FLASH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEADY     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREATHE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP = 3'd4;

   // Register reset values
   localparam logic [LEN_BITS-1:0]   BLINK_HALF_RST = 16'd500;
   localparam logic [LEN_BITS-1:0]   FLASH_RST      = 16'd100;
   localparam logic [LEN_BITS-1:0]   STEADY_RST     = 16'd100;
   localparam logic [LEN_BITS-1:0]   BREATHE_RST    = 16'd30;
   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 16'd1043;

   // Configuration bundle
   typedef struct packed {
      logic [LEN_BITS-1:0]   blink_half_ticks;
      logic [LEN_BITS-1:0]   flash_ticks;
      logic [LEN_BITS-1:0]   steady_ticks;
      logic [LEN_BITS-1:0]   breathe_ticks;
      logic [PHASE_BITS-1:0] phase_step;
   } cfg_type;

   // One command item
   typedef struct packed {
      op_type     op;
      logic [2:0] mode;
   } item_type;

   // Visible LED status
   typedef struct packed {
      logic [DUTY_BITS-1:0] red_duty;
      logic [DUTY_BITS-1:0] green_duty;
      logic                 flashing;
   } status_type;

   // A zero length counts as one tick
   function automatic logic [LEN_BITS-1:0] len_of(input logic [LEN_BITS-1:0] v);
      return (v == '0) ? LEN_BITS'(1) : v;
   endfunction

   // ---------------------------------------------------------------------
   // Sine ROM, built at elaboration.
   // Quarter-wave Taylor polynomial in Q30, Horner form, truncating products.
   // ---------------------------------------------------------------------
   localparam longint Q30        = longint'(1) << 30;
   localparam int     QUARTER    = TABLE_SIZE / 4;
   localparam int     QTR_SHIFT  = 30 - (SINE_INDEX_BITS - 2);

   typedef logic [DUTY_BITS-1:0] sine_rom_type [TABLE_SIZE];

   function automatic longint quarter_sine(input longint r);
      longint t;
      longint t2;
      longint p;
      t  = r <<< QTR_SHIFT;
      t2 = (t * t) / Q30;
      p  = 172272;
      p  = -5026995   + (p * t2) / Q30;
      p  = 85569306   + (p * t2) / Q30;
      p  = -693598669 + (p * t2) / Q30;
      p  = 1686629713 + (p * t2) / Q30;
      p  = (p * t) / Q30;
      if (p < 0) p = 0;
      if (p > Q30) p = Q30;
      return p;
   endfunction

   function automatic sine_rom_type build_sine_table();
      sine_rom_type tbl;
      longint       q;
      longint       r;
      longint       s;
      longint       e;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         q = longint'(i) / QUARTER;
         r = longint'(i) % QUARTER;
         case (q)
            0:       s = quarter_sine(r);
            1:       s = quarter_sine(QUARTER - r);
            2:       s = -quarter_sine(r);
            default: s = -quarter_sine(QUARTER - r);
         endcase
         e = ((s + Q30) * longint'(DUTY_MAX)) >>> 31;
         tbl[i] = e[DUTY_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam sine_rom_type SINE_TABLE = build_sine_table();

endpackage

// ===== sv/lsps_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status pattern sequencer - configuration registers
// Five 16-bit timing registers written over the csr channel.
// ----------------------------------------------------------------------------
module lsps_csr
   import lsps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_BLINK_HALF: cfg_in.blink_half_ticks = csr_data;
            REG_FLASH:      cfg_in.flash_ticks      = csr_data;
            REG_STEADY:     cfg_in.steady_ticks     = csr_data;
            REG_BREATHE:    cfg_in.breathe_ticks    = csr_data;
            REG_PHASE_STEP: cfg_in.phase_step       = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_half_ticks <= BLINK_HALF_RST;
         cfg_ff.flash_ticks      <= FLASH_RST;
         cfg_ff.steady_ticks     <= STEADY_RST;
         cfg_ff.breathe_ticks    <= BREATHE_RST;
         cfg_ff.phase_step       <= PHASE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/lsps_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status pattern sequencer - pattern engine
// Segment state, flash sequencing and breathe phase. The sine ROM is read
// with the next phase value, so its registered output always matches the
// phase register.
// ----------------------------------------------------------------------------
module lsps_engine
   import lsps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output status_type status
);

   localparam logic [DUTY_BITS-1:0] SINE_AT_ZERO = SINE_TABLE[0];

   mode_type              mode_ff,    mode_in;
   logic                  pend_ff,    pend_in;
   logic                  tx_ff,      tx_in;
   logic                  run_ff,     run_in;
   logic [1:0]            seg_ff,     seg_in;
   logic [LEN_BITS-1:0]   ticks_ff,   ticks_in;
   logic [PHASE_BITS-1:0] phase_ff,   phase_in;
   logic [DUTY_BITS-1:0]  red_ff,     red_in;
   logic [DUTY_BITS-1:0]  green_ff,   green_in;
   logic [DUTY_BITS-1:0]  sine_ff;
   logic [SINE_INDEX_BITS-1:0] rom_addr;

   // Next state for one item
   always_comb begin
      logic                 fall;
      logic [DUTY_BITS-1:0] lvl;
      logic [DUTY_BITS-1:0] sine_v;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      tx_in    = tx_ff;
      run_in   = run_ff;
      seg_in   = seg_ff;
      ticks_in = ticks_ff;
      phase_in = phase_ff;
      red_in   = red_ff;
      green_in = green_ff;
      fall     = 1'b1;
      lvl      = DUTY_OFF;
      sine_v   = sine_ff;
      if (fire) begin
         case (item.op)
            OP_TICK: begin
               if (ticks_ff == '0) begin
                  // Segment boundary
                  if (run_ff) begin
                     if (seg_ff < 2'd2) begin
                        seg_in = seg_ff + 2'd1;
                        lvl    = (seg_in == 2'd2) ? DUTY_MAX : DUTY_OFF;
                        if (tx_ff) green_in = lvl;
                        else       red_in   = lvl;
                        ticks_in = len_of(cfg.flash_ticks);
                        fall     = 1'b0;
                     end else begin
                        // Flash end: colour off, pattern restarts at phase zero
                        if (tx_ff) green_in = DUTY_OFF;
                        else       red_in   = DUTY_OFF;
                        run_in   = 1'b0;
                        phase_in = '0;
                        sine_v   = SINE_AT_ZERO;
                     end
                  end else if (seg_ff == 2'd1 && !pend_ff && mode_ff == MODE_CONNECT) begin
                     // Connecting blink, dark half
                     red_in   = DUTY_OFF;
                     green_in = DUTY_OFF;
                     seg_in   = 2'd0;
                     ticks_in = len_of(cfg.blink_half_ticks);
                     fall     = 1'b0;
                  end else if (seg_ff == 2'd2 && !pend_ff && mode_ff == MODE_TOOL) begin
                     // Tool-use blink, dark half
                     green_in = DUTY_OFF;
                     seg_in   = 2'd0;
                     ticks_in = len_of(cfg.blink_half_ticks);
                     fall     = 1'b0;
                  end
                  if (fall) begin
                     seg_in = 2'd0;
                     if (pend_ff) begin
                        // Flash start
                        pend_in = 1'b0;
                        run_in  = 1'b1;
                        if (tx_ff) begin
                           red_in   = DUTY_OFF;
                           green_in = DUTY_MAX;
                        end else begin
                           red_in   = DUTY_MAX;
                           green_in = DUTY_OFF;
                        end
                        ticks_in = len_of(cfg.flash_ticks);
                     end else begin
                        case (mode_ff)
                           MODE_CONNECT: begin
                              red_in   = DUTY_MAX;
                              green_in = DUTY_MAX;
                              seg_in   = 2'd1;
                              ticks_in = len_of(cfg.blink_half_ticks);
                           end
                           MODE_THINK: begin
                              red_in   = DUTY_OFF;
                              green_in = sine_v;
                              phase_in = phase_in + cfg.phase_step;
                              ticks_in = len_of(cfg.breathe_ticks);
                           end
                           MODE_TOOL: begin
                              red_in   = DUTY_OFF;
                              green_in = DUTY_MAX;
                              seg_in   = 2'd2;
                              ticks_in = len_of(cfg.blink_half_ticks);
                           end
                           MODE_ERROR: begin
                              green_in = DUTY_OFF;
                              red_in   = sine_v;
                              phase_in = phase_in + cfg.phase_step;
                              ticks_in = len_of(cfg.breathe_ticks);
                           end
                           default: begin
                              red_in   = DUTY_OFF;
                              green_in = DUTY_MAX;
                              ticks_in = len_of(cfg.steady_ticks);
                           end
                        endcase
                     end
                  end
               end
               ticks_in = ticks_in - LEN_BITS'(1);
            end
            OP_SET_MODE: begin
               // Out-of-range modes are ignored
               if (item.mode <= MODE_ERROR) mode_in = mode_type'(item.mode);
            end
            default: begin
               // Flash trigger, dropped while a flash runs
               if (!run_ff) begin
                  pend_in = 1'b1;
                  tx_in   = (item.op == OP_TX_FLASH);
               end
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= 1'b0;
         tx_ff    <= 1'b0;
         run_ff   <= 1'b0;
         seg_ff   <= 2'd0;
         ticks_ff <= '0;
         phase_ff <= '0;
         red_ff   <= DUTY_OFF;
         green_ff <= DUTY_OFF;
      end else begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         tx_ff    <= tx_in;
         run_ff   <= run_in;
         seg_ff   <= seg_in;
         ticks_ff <= ticks_in;
         phase_ff <= phase_in;
         red_ff   <= red_in;
         green_ff <= green_in;
      end
   end

   // Sine ROM, registered read at the phase the next item will see
   assign rom_addr = reset ? '0 : phase_in[PHASE_BITS-1 -: SINE_INDEX_BITS];

   always_ff @(posedge clock) begin
      sine_ff <= SINE_TABLE[rom_addr];
   end

   assign status.red_duty   = red_ff;
   assign status.green_duty = green_ff;
   assign status.flashing   = run_ff;

endmodule

// ===== sv/led_status_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status pattern sequencer - top level
// Red/green LED duty sequencer driven by ticks, mode sets and flash triggers.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  req     | in        | req_tvalid/tready   | tuser: op; tdata: mode
//  rsp     | out       | rsp_tvalid/tready   | tdata: red, green, flashing
//  csr     | in        | csr_valid/ready     | csr_index, csr_data
//
// One item per cycle while no result is held. An item waits in the input
// register and is applied as it moves into the result register. The sine
// ROM read is registered and addressed by the next phase.
// A held result stalls the input register; one more item can wait there.
// Reset clears all state and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module led_status_pattern_sequencer_core
   import lsps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [2:0] mode, rest zero
   input  logic [1:0]                req_tuser,   // [1:0] op
   // Result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // [12:0] red_duty, [25:13] green_duty,
                                                  // [26] flashing, rest zero
   // Configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data
);

   logic       req_vld_ff;
   item_type   req_item_ff;
   logic       rsp_vld_ff;
   logic       advance;
   cfg_type    cfg;
   status_type status;

   // Configuration registers
   lsps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Item moves on when the result slot is empty or being drained
   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         req_vld_ff <= 1'b1;
      end else if (advance) begin
         req_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_item_ff.op   <= op_type'(req_tuser);
         req_item_ff.mode <= req_tdata[2:0];
      end
   end

   // Pattern engine; its state registers are the result payload
   lsps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (req_item_ff),
      .cfg    (cfg),
      .status (status)
   );

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, status.flashing, status.green_duty, status.red_duty};

endmodule

// ===== sv/lsps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status pattern sequencer - port checker
// Watches the top-level ports for stall, reset and flash-level rules.
// ----------------------------------------------------------------------------
module lsps_checker
   import lsps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic [DUTY_BITS-1:0] red;
   logic [DUTY_BITS-1:0] green;
   logic                 flashing;

   assign red      = rsp_tdata[DUTY_BITS-1:0];
   assign green    = rsp_tdata[2*DUTY_BITS-1:DUTY_BITS];
   assign flashing = rsp_tdata[2*DUTY_BITS];

   // A held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input only stalls behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with result side free");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

   // During a flash both colours are fully on or off and one is dark
   a_flash_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && flashing |->
         (red == DUTY_OFF || green == DUTY_OFF) &&
         (red == DUTY_OFF || red == DUTY_MAX) &&
         (green == DUTY_OFF || green == DUTY_MAX))
      else $error("flash levels out of pattern");

endmodule

bind led_status_pattern_sequencer_core lsps_checker u_lsps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
